// ----- hw/rtl/homogeneous_matrix_transform_top_macros.svh -----
// Assertion helpers, clocked on clk and disabled in reset.
`ifndef HOMOGENEOUS_MATRIX_TRANSFORM_TOP_MACROS_SVH
`define HOMOGENEOUS_MATRIX_TRANSFORM_TOP_MACROS_SVH

// same-cycle implication
`define HMT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/hmt_pkg.sv -----
package hmt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int SH_BITS   = PROD_BITS - FRAC_BITS;
  localparam int ACC_BITS  = WORD_BITS + 2;

  localparam int IN_DATA_BITS  = ((4 + 4 * WORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = 4 * WORD_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [SH_BITS-1:0]   shifted_t;
  typedef logic signed [ACC_BITS-1:0]  acc_t;

  typedef enum logic [2:0] {
    KIND_WR_CUR = 3'd0,
    KIND_WR_OPD = 3'd1,
    KIND_COMPOSE = 3'd2,
    KIND_XFORM = 3'd3,
    KIND_IDENT = 3'd4,
    KIND_SCALE = 3'd5,
    KIND_USCALE = 3'd6,
    KIND_TRANS = 3'd7
  } kind_t;

  localparam word_t UNIT = word_t'(1 << FRAC_BITS);

  typedef struct packed {
    logic       vld;
    logic       first;
    logic       last;
    logic       fin;
    logic [1:0] col;
    logic [1:0] row;
  } mac_tag_t;

  typedef struct packed {
    logic       vld;
    logic       fin;
    logic [1:0] col;
    logic [1:0] row;
    word_t      val;
  } mac_res_t;

  typedef struct packed {
    logic       ident;
    logic       wr_cur;
    logic       wr_opd;
    logic [3:0] idx;
    word_t      val;
    logic       row_wr;
    logic [1:0] row;
  } mat_cmd_t;

  function automatic word_t sat_shifted(shifted_t v);
    if ((&v[SH_BITS-1:WORD_BITS-1]) || !(|v[SH_BITS-1:WORD_BITS-1]))
      return v[WORD_BITS-1:0];
    return {v[SH_BITS-1], {(WORD_BITS-1){~v[SH_BITS-1]}}};
  endfunction

  function automatic word_t sat_acc(acc_t v);
    if ((&v[ACC_BITS-1:WORD_BITS-1]) || !(|v[ACC_BITS-1:WORD_BITS-1]))
      return v[WORD_BITS-1:0];
    return {v[ACC_BITS-1], {(WORD_BITS-1){~v[ACC_BITS-1]}}};
  endfunction

  function automatic logic is_diag(logic [3:0] idx);
    return idx[1:0] == idx[3:2];
  endfunction

  // right-hand matrix of scale / uniform scale / translate
  function automatic word_t aux_elem(kind_t kind, logic [3:0] idx,
                                     word_t x, word_t y, word_t z);
    word_t e;
    e = is_diag(idx) ? UNIT : '0;
    if (kind == KIND_TRANS) begin
      if (idx == 4'd12) e = x;
      if (idx == 4'd13) e = y;
      if (idx == 4'd14) e = z;
    end else begin
      if (idx == 4'd0) e = x;
      if (idx == 4'd5) e = (kind == KIND_SCALE) ? y : x;
      if (idx == 4'd10) e = (kind == KIND_SCALE) ? z : x;
    end
    return e;
  endfunction

endpackage

// ----- hw/rtl/homogeneous_matrix_transform_top.sv -----
// Element writes and identity are applied at the accepting edge; the block stays ready.
// Vector transform: 16 multiply-accumulates on the shared MAC; the block is ready again
// once the result is loaded into the output register.
// Compose, scale, uniform scale and translate: 64 MACs; ready again when the last row is written back.
// Rate is set by the single 32x32 MAC; a result waiting for the output register blocks input.
// Reset (rst, sync): both matrices to identity, output empty, sequencer idle.
module homogeneous_matrix_transform_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // elem_index, arg_x, arg_y, arg_z, arg_w, zero pad
  input  logic [hmt_pkg::IN_DATA_BITS-1:0]  s_tdata,
  // kind
  input  logic [2:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // out_x, out_y, out_z, out_w
  output logic [hmt_pkg::OUT_DATA_BITS-1:0] m_tdata
);
  import hmt_pkg::*;
  `include "homogeneous_matrix_transform_top_macros.svh"

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_OUTQ  = 2'd3;

  logic [1:0] state;
  logic [5:0] step;
  kind_t      op_kind;
  word_t      ax, ay, az, aw;
  word_t      lane [4];

  kind_t      in_kind;
  logic [3:0] in_idx;
  word_t      in_x, in_y, in_z, in_w;
  logic       accept;
  logic       is_xf;
  logic [5:0] last_step;
  logic [1:0] k, c, r;

  mac_tag_t   tag;
  mac_res_t   res;
  mat_cmd_t   cmd;
  word_t      row_val [4];
  logic [3:0] cur_addr, opd_addr;
  word_t      cur_rd, opd_rd;
  word_t      mac_a, mac_b;
  word_t      vec_k;
  logic       out_load;

  assign in_kind = kind_t'(s_tuser);
  assign in_idx  = s_tdata[3:0];
  assign in_x    = s_tdata[4 + WORD_BITS-1 : 4];
  assign in_y    = s_tdata[4 + 2*WORD_BITS-1 : 4 + WORD_BITS];
  assign in_z    = s_tdata[4 + 3*WORD_BITS-1 : 4 + 2*WORD_BITS];
  assign in_w    = s_tdata[4 + 4*WORD_BITS-1 : 4 + 3*WORD_BITS];

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign is_xf     = (op_kind == KIND_XFORM);
  assign last_step = is_xf ? 6'd15 : 6'd63;
  assign k = step[1:0];
  assign c = step[3:2];
  assign r = step[5:4];

  always_comb begin
    unique case (k)
      2'd0: vec_k = ax;
      2'd1: vec_k = ay;
      2'd2: vec_k = az;
      default: vec_k = aw;
    endcase
    opd_addr = {k, c};
    cur_addr = is_xf ? {k, c} : {r, k};
    mac_a = is_xf ? vec_k : cur_rd;
    if (is_xf) begin
      mac_b = cur_rd;
    end else if (op_kind == KIND_COMPOSE) begin
      mac_b = opd_rd;
    end else begin
      mac_b = aux_elem(op_kind, {k, c}, ax, ay, az);
    end
    tag.vld   = (state == ST_RUN);
    tag.first = (k == 2'd0);
    tag.last  = (k == 2'd3);
    tag.fin   = (step == last_step);
    tag.col   = c;
    tag.row   = r;
  end

  always_comb begin
    cmd.ident  = accept && (in_kind == KIND_IDENT);
    cmd.wr_cur = accept && (in_kind == KIND_WR_CUR);
    cmd.wr_opd = accept && (in_kind == KIND_WR_OPD);
    cmd.idx    = in_idx;
    cmd.val    = in_x;
    cmd.row_wr = res.vld && (res.col == 2'd3) && !is_xf;
    cmd.row    = res.row;
    row_val[0] = lane[0];
    row_val[1] = lane[1];
    row_val[2] = lane[2];
    row_val[3] = res.val;
  end

  hmt_mac u_mac (
    .clk (clk),
    .rst (rst),
    .tag (tag),
    .a   (mac_a),
    .b   (mac_b),
    .res (res)
  );

  hmt_mat u_mat (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .row_val  (row_val),
    .cur_addr (cur_addr),
    .opd_addr (opd_addr),
    .cur_rd   (cur_rd),
    .opd_rd   (opd_rd)
  );

  assign out_load = (state == ST_OUTQ) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind <= in_kind;
      ax <= in_x;
      ay <= in_y;
      az <= in_z;
      aw <= in_w;
    end
    if (res.vld) begin
      lane[res.col] <= res.val;
    end
    if (out_load) begin
      m_tdata <= {lane[3], lane[2], lane[1], lane[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          step <= '0;
          if (accept && in_kind != KIND_WR_CUR && in_kind != KIND_WR_OPD &&
              in_kind != KIND_IDENT) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          step <= step + 6'd1;
          if (step == last_step) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (res.vld && res.fin) begin
            state <= is_xf ? ST_OUTQ : ST_IDLE;
          end
        end
        ST_OUTQ: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `HMT_ASSERT_SAME(a_res_in_op, res.vld, (state == ST_RUN || state == ST_DRAIN), "MAC result outside an operation")
  `HMT_ASSERT_SAME(a_xf_step, (state == ST_RUN && is_xf), (step < 6'd16), "transform step out of range")
  `HMT_ASSERT_NEXT(a_busy_after_long, (accept && (in_kind == KIND_XFORM || in_kind == KIND_COMPOSE)), !s_tready, "ready during MAC sequence")
  `HMT_ASSERT_SAME(a_row_wr_idle, cmd.row_wr, !accept, "row commit while accepting request")

endmodule

// ----- hw/rtl/hmt_mac.sv -----
module hmt_mac (
  input  logic              clk,
  input  logic              rst,
  input  hmt_pkg::mac_tag_t tag,
  input  hmt_pkg::word_t    a,
  input  hmt_pkg::word_t    b,
  output hmt_pkg::mac_res_t res
);
  import hmt_pkg::*;

  prod_t    prod;
  mac_tag_t tag1;
  acc_t     acc;
  acc_t     acc_next;
  shifted_t sh;
  word_t    term;

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (rst) begin
      tag1 <= '0;
    end else begin
      tag1 <= tag;
    end
  end

  always_comb begin
    sh = prod[PROD_BITS-1:FRAC_BITS];
    term = sat_shifted(sh);
    acc_next = (tag1.first ? acc_t'(0) : acc) + ACC_BITS'(term);
  end

  always_ff @(posedge clk) begin
    if (tag1.vld) begin
      acc <= acc_next;
    end
    res.fin <= tag1.fin;
    res.col <= tag1.col;
    res.row <= tag1.row;
    res.val <= sat_acc(acc_next);
    if (rst) begin
      res.vld <= 1'b0;
    end else begin
      res.vld <= tag1.vld && tag1.last;
    end
  end

endmodule

// ----- hw/rtl/hmt_mat.sv -----
module hmt_mat (
  input  logic              clk,
  input  logic              rst,
  input  hmt_pkg::mat_cmd_t cmd,
  input  hmt_pkg::word_t    row_val [4],
  input  logic [3:0]        cur_addr,
  input  logic [3:0]        opd_addr,
  output hmt_pkg::word_t    cur_rd,
  output hmt_pkg::word_t    opd_rd
);
  import hmt_pkg::*;

  word_t cur [16];
  word_t opd [16];

  assign cur_rd = cur[cur_addr];
  assign opd_rd = opd[opd_addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        cur[i] <= is_diag(4'(i)) ? UNIT : '0;
        opd[i] <= is_diag(4'(i)) ? UNIT : '0;
      end
    end else begin
      if (cmd.ident) begin
        for (int i = 0; i < 16; i++) begin
          cur[i] <= is_diag(4'(i)) ? UNIT : '0;
        end
      end
      if (cmd.wr_cur) begin
        cur[cmd.idx] <= cmd.val;
      end
      if (cmd.wr_opd) begin
        opd[cmd.idx] <= cmd.val;
      end
      if (cmd.row_wr) begin
        for (int c = 0; c < 4; c++) begin
          cur[{cmd.row, 2'(c)}] <= row_val[c];
        end
      end
    end
  end

endmodule
